[sv/gfd_pkg.sv]
package gfd_pkg;

	// receive phase of the deframer
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_RESP  = 3'd1,
		PH_DELTA = 3'd2,
		PH_COUNT = 3'd3,
		PH_PADID = 3'd4,
		PH_BYTES = 3'd5,
		PH_SUM   = 3'd6
	} phase_t;

	localparam logic [7:0] HDR_FIRST   = 8'h01;
	localparam logic [7:0] HDR_SECOND  = 8'hFE;
	localparam logic [7:0] DELTA_RESET = 8'hFF;
	localparam logic [1:0] LAST_LANE   = 2'd3;
	localparam int         PAD_BUTTONS = 16;

	typedef struct packed {
		logic [15:0] held;
		logic [15:0] toggle;
	} pad_bits_t;

	// four buttons per byte, count bit above held bit, first button at the top
	function automatic pad_bits_t split_pad(input logic [31:0] raw);
		pad_bits_t r;
		r = '0;
		for (int i = 0; i < PAD_BUTTONS; i++) begin
			r.held[i]   = raw[8 * (i / 4) + 6 - 2 * (i % 4)];
			r.toggle[i] = raw[8 * (i / 4) + 7 - 2 * (i % 4)];
		end
		return r;
	endfunction

endpackage

[sv/gamepad_frame_deframer_top.sv]
// Deframer for the game-controller status link. One received byte is taken per request on
// in_valid/in_ready; the block hunts for the header pair 01 FE, then reads response id,
// delta id, record count and that many five-byte records (pad number plus four button
// bytes), and on the trailing additive checksum byte it presents one result request on
// out_valid/out_ready. Pads 0 and 1 are decoded into held and count bits (zero when the pad
// had no record); other pad numbers only enter the sum. A frame is taken as good when the
// checksum matches and the delta id differs from the last good one, and a good frame updates
// the acknowledge id. Throughput is one byte per clock while in_ready is high: each byte is a
// single update of the phase register and frame registers, and the result register holds the
// result in the cycle after the checksum byte is taken. in_ready only drops while a finished
// result waits in the result register and out_ready is low.
module gamepad_frame_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic        sum_error,
	output logic        repeated_delta,
	output logic [7:0]  response_number,
	output logic [7:0]  delta_number,
	output logic [1:0]  pads_present,
	output logic [15:0] pad0_held,
	output logic [15:0] pad0_toggle,
	output logic [15:0] pad1_held,
	output logic [15:0] pad1_toggle,
	output logic [7:0]  ack_number
);

	// frame state
	gfd_pkg::phase_t phase_q;
	logic [7:0]  prev_byte_q;
	logic [7:0]  frame_resp_q;
	logic [7:0]  frame_delta_q;
	logic [7:0]  records_left_q;
	logic        rec_known_q;   // record belongs to pad 0 or 1
	logic        rec_sel_q;     // which of the two pads
	logic [1:0]  lane_q;
	logic [7:0]  sum_q;
	logic [31:0] pad_raw_q [2];
	logic [1:0]  present_q;
	logic [7:0]  acc_delta_q;
	logic [7:0]  acc_resp_q;

	// result register
	logic        out_valid_q;
	logic        frame_ok_q;
	logic        sum_error_q;
	logic        repeated_q;
	logic [7:0]  resp_out_q;
	logic [7:0]  delta_out_q;
	logic [1:0]  present_out_q;
	gfd_pkg::pad_bits_t pad0_q;
	gfd_pkg::pad_bits_t pad1_q;
	logic [7:0]  ack_q;

	logic take;
	logic bad_sum;
	logic repeated;
	logic good;
	logic [7:0] records_next;
	gfd_pkg::pad_bits_t pad0_split;
	gfd_pkg::pad_bits_t pad1_split;

	// a new byte can enter unless the result register is full and stalled
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	assign bad_sum      = rx_byte != sum_q;
	assign repeated     = frame_delta_q == acc_delta_q;
	assign good         = !bad_sum && !repeated;
	assign records_next = records_left_q - 8'd1;
	assign pad0_split   = gfd_pkg::split_pad(pad_raw_q[0]);
	assign pad1_split   = gfd_pkg::split_pad(pad_raw_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= gfd_pkg::PH_HUNT;
			prev_byte_q    <= '0;
			frame_resp_q   <= '0;
			frame_delta_q  <= '0;
			records_left_q <= '0;
			rec_known_q    <= 1'b0;
			rec_sel_q      <= 1'b0;
			lane_q         <= '0;
			sum_q          <= '0;
			pad_raw_q[0]   <= '0;
			pad_raw_q[1]   <= '0;
			present_q      <= '0;
			acc_delta_q    <= gfd_pkg::DELTA_RESET;
			acc_resp_q     <= '0;
		end else if (take) begin
			case (phase_q)
				gfd_pkg::PH_RESP: begin
					frame_resp_q <= rx_byte;
					sum_q        <= rx_byte;
					phase_q      <= gfd_pkg::PH_DELTA;
				end
				gfd_pkg::PH_DELTA: begin
					frame_delta_q <= rx_byte;
					sum_q         <= sum_q + rx_byte;
					phase_q       <= gfd_pkg::PH_COUNT;
				end
				gfd_pkg::PH_COUNT: begin
					records_left_q <= rx_byte;
					sum_q          <= sum_q + rx_byte;
					phase_q        <= (rx_byte == 8'd0) ? gfd_pkg::PH_SUM : gfd_pkg::PH_PADID;
				end
				gfd_pkg::PH_PADID: begin
					rec_known_q <= rx_byte[7:1] == 7'd0;
					rec_sel_q   <= rx_byte[0];
					lane_q      <= '0;
					sum_q       <= sum_q + rx_byte;
					// a repeated pad starts over, so its last record wins
					if (rx_byte[7:1] == 7'd0) begin
						present_q[rx_byte[0]] <= 1'b1;
						pad_raw_q[rx_byte[0]] <= '0;
					end
					phase_q <= gfd_pkg::PH_BYTES;
				end
				gfd_pkg::PH_BYTES: begin
					sum_q <= sum_q + rx_byte;
					if (rec_known_q)
						pad_raw_q[rec_sel_q][{lane_q, 3'b000} +: 8] <= rx_byte;
					if (lane_q == gfd_pkg::LAST_LANE) begin
						lane_q         <= '0;
						records_left_q <= records_next;
						phase_q        <= (records_next == 8'd0) ? gfd_pkg::PH_SUM
						                                         : gfd_pkg::PH_PADID;
					end else begin
						lane_q <= lane_q + 2'd1;
					end
				end
				gfd_pkg::PH_SUM: begin
					if (good) begin
						acc_delta_q <= frame_delta_q;
						acc_resp_q  <= frame_resp_q;
					end
					// checksum byte never forms half of the next header
					prev_byte_q <= '0;
					phase_q     <= gfd_pkg::PH_HUNT;
				end
				default: begin
					if (prev_byte_q == gfd_pkg::HDR_FIRST && rx_byte == gfd_pkg::HDR_SECOND) begin
						phase_q        <= gfd_pkg::PH_RESP;
						present_q      <= '0;
						pad_raw_q[0]   <= '0;
						pad_raw_q[1]   <= '0;
						records_left_q <= '0;
						lane_q         <= '0;
						sum_q          <= '0;
						prev_byte_q    <= '0;
					end else begin
						phase_q     <= gfd_pkg::PH_HUNT;
						prev_byte_q <= rx_byte;
					end
				end
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && phase_q == gfd_pkg::PH_SUM) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on the checksum byte
	always_ff @(posedge clk) begin
		if (take && phase_q == gfd_pkg::PH_SUM) begin
			frame_ok_q    <= good;
			sum_error_q   <= bad_sum;
			repeated_q    <= repeated;
			resp_out_q    <= frame_resp_q;
			delta_out_q   <= frame_delta_q;
			present_out_q <= present_q;
			pad0_q        <= present_q[0] ? pad0_split : '0;
			pad1_q        <= present_q[1] ? pad1_split : '0;
			ack_q         <= good ? frame_resp_q : acc_resp_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_ok        = frame_ok_q;
	assign sum_error       = sum_error_q;
	assign repeated_delta  = repeated_q;
	assign response_number = resp_out_q;
	assign delta_number    = delta_out_q;
	assign pads_present    = present_out_q;
	assign pad0_held       = pad0_q.held;
	assign pad0_toggle     = pad0_q.toggle;
	assign pad1_held       = pad1_q.held;
	assign pad1_toggle     = pad1_q.toggle;
	assign ack_number      = ack_q;

endmodule

[sv/gfd_checker.sv]
module gfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        frame_ok,
	input logic        sum_error,
	input logic        repeated_delta,
	input logic [7:0]  response_number,
	input logic [7:0]  delta_number,
	input logic [1:0]  pads_present,
	input logic [15:0] pad0_held,
	input logic [15:0] pad0_toggle,
	input logic [15:0] pad1_held,
	input logic [15:0] pad1_toggle,
	input logic [7:0]  ack_number
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_ok) && $stable(ack_number)
			&& $stable(pad0_held) && $stable(pad1_held) && $stable(delta_number))
		else $error("result changed while stalled");

	// full result register blocks input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	a_ok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_ok == (!sum_error && !repeated_delta))
		else $error("frame_ok inconsistent with error flags");

	a_ack_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> ack_number == response_number)
		else $error("good frame did not update acknowledge id");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pads_present[0] || (pad0_held == 16'd0 && pad0_toggle == 16'd0))
			&& (pads_present[1] || (pad1_held == 16'd0 && pad1_toggle == 16'd0)))
		else $error("absent pad carries button bits");

endmodule

bind gamepad_frame_deframer_top gfd_checker u_gfd_checker (.*);
